// File: sv/nsm_pkg.sv
package nsm_pkg;

  // Token buffer geometry
  localparam int unsigned MAX_TOKEN = 32;
  localparam int unsigned LEN_W     = $clog2(MAX_TOKEN + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_TOKEN);

  // Character codes
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NL      = 8'd10;
  localparam logic [7:0] CHAR_QUEST   = 8'd63;
  localparam logic [7:0] CHAR_COMMA   = 8'd44;
  localparam logic [7:0] CHAR_STOP    = 8'd46;
  localparam logic [7:0] CHAR_SEMI    = 8'd59;
  localparam logic [7:0] CHAR_COLON   = 8'd58;
  localparam logic [7:0] CHAR_EXCL    = 8'd33;
  localparam logic [7:0] CHAR_N_LOW   = 8'd110;
  localparam logic [7:0] CHAR_APOS    = 8'd39;
  localparam logic [7:0] CHAR_T_LOW   = 8'd116;

  // "NEG_" prefix, emitted first character first
  localparam int unsigned PREFIX_LEN = 4;
  localparam logic [PREFIX_LEN*8-1:0] PREFIX_STR = "NEG_";

  // Fixed negation words, right-justified strings with their lengths
  localparam int unsigned NEG_WORD_COUNT = 21;
  localparam int unsigned WORD_MAX       = 8;
  localparam logic [WORD_MAX*8-1:0] NEG_WORD [NEG_WORD_COUNT] = '{
    "never", "no", "nothing", "nowhere", "noone", "none", "not",
    "havent", "hasnt", "hadnt", "cant", "couldnt", "shouldnt", "wont",
    "wouldnt", "dont", "doesnt", "didnt", "isnt", "arent", "aint"
  };
  localparam logic [3:0] NEG_WORD_LEN [NEG_WORD_COUNT] = '{
    4'd5, 4'd2, 4'd7, 4'd7, 4'd5, 4'd4, 4'd3,
    4'd6, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd4,
    4'd7, 4'd4, 4'd6, 4'd5, 4'd4, 4'd5, 4'd4
  };

  // Request and result payloads
  typedef struct packed {
    logic [7:0] text_byte;
    logic       flush;
  } nsm_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       token_truncated;
  } nsm_out_t;

  // Sequencer to word scanner
  typedef struct packed {
    logic start;
    logic step;
  } nsm_scan_t;

  // Word scanner to sequencer
  typedef struct packed {
    logic word_hit;
    logic last_mark;
  } nsm_hit_t;

  // Sentence punctuation that closes a negation scope
  function automatic logic is_mark(logic [7:0] c);
    return (c == CHAR_QUEST) || (c == CHAR_COMMA) || (c == CHAR_STOP) ||
           (c == CHAR_SEMI)  || (c == CHAR_COLON) || (c == CHAR_EXCL);
  endfunction

  // Character i of negation word w (valid for i below the word length)
  function automatic logic [7:0] word_char(int unsigned w, logic [2:0] i);
    logic [3:0] pos;
    pos = NEG_WORD_LEN[w] - 4'd1 - {1'b0, i};
    return NEG_WORD[w][{pos[2:0], 3'b000} +: 8];
  endfunction

  // Character i of the prefix
  function automatic logic [7:0] prefix_char(logic [1:0] i);
    logic [1:0] pos;
    pos = 2'(PREFIX_LEN - 1) - i;
    return PREFIX_STR[{pos, 3'b000} +: 8];
  endfunction

endpackage

// File: sv/nsm_word_match.sv
module nsm_word_match import nsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsm_scan_t        scan_i,
  input  logic [7:0]       byte_i,
  input  logic [LEN_W-1:0] ptr_i,
  input  logic [LEN_W-1:0] len_i,
  output nsm_hit_t         hit_o
);

  logic [NEG_WORD_COUNT-1:0] match_q, match_d;
  logic [23:0]               tail_q;
  logic [NEG_WORD_COUNT-1:0] len_eq;
  logic                      nt_hit;

  // Per-word compare of the byte at the current position
  always_comb begin
    match_d = match_q;
    if (scan_i.start) begin
      match_d = '1;
    end else if (scan_i.step) begin
      for (int unsigned w = 0; w < NEG_WORD_COUNT; w++) begin
        if (!(ptr_i < LEN_W'(NEG_WORD_LEN[w]) && byte_i == word_char(w, ptr_i[2:0]))) begin
          match_d[w] = 1'b0;
        end
      end
    end
  end

  // Match vector and last three bytes seen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.step) begin
      tail_q <= {tail_q[15:0], byte_i};
    end
  end

  // Whole-word match needs equal length
  always_comb begin
    for (int unsigned w = 0; w < NEG_WORD_COUNT; w++) begin
      len_eq[w] = (len_i == LEN_W'(NEG_WORD_LEN[w]));
    end
  end

  assign nt_hit = (len_i >= LEN_W'(3)) && (tail_q[23:16] == CHAR_N_LOW) &&
                  (tail_q[15:8] == CHAR_APOS) && (tail_q[7:0] == CHAR_T_LOW);

  assign hit_o.word_hit  = nt_hit || (|(match_q & len_eq));
  assign hit_o.last_mark = is_mark(tail_q[7:0]);

endmodule

// File: sv/negation_scope_token_marker.sv
// Negation scope marker: takes one text byte per request and emits the marked
// text one byte per result. Token bytes, spaces that end no token and flushes of
// an empty token are taken without a stall and give no result. A request that
// ends a token (space, newline or flush) holds the input while the block emits
// the NEG_ prefix when negated, the stored bytes and the closing space or newline:
// the single read port of the token buffer gives each registered byte in S_READ
// before S_EMIT passes it on, and the result register takes one byte per
// cycle when it is not stalled. A result waiting in the output register does not
// hold back token bytes. Bytes past MAX_TOKEN are dropped and flagged.
module negation_scope_token_marker import nsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nsm_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nsm_out_t out_rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFIX,
    S_READ,
    S_EMIT,
    S_TAIL
  } state_e;

  state_e           state_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] ptr_q;
  logic [1:0]       pcnt_q;
  logic             neg_q;
  logic             ovf_q;
  logic             line_q;
  logic             flush_q;
  logic [7:0]       first_q;
  logic             out_valid_q;
  nsm_out_t         out_q;

  logic [7:0]       mem_q [MAX_TOKEN];
  logic [7:0]       rdata_q;

  logic             accept;
  logic             slot_free;
  logic             out_load;
  logic             is_data;
  logic             fin_go;
  logic             fin_line;
  logic             neg_eff;
  logic             mem_we;
  nsm_scan_t        scan;
  nsm_hit_t         hit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_load    = slot_free && (state_q inside {S_PREFIX, S_EMIT, S_TAIL});
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Decode of an accepted request
  always_comb begin
    is_data  = !in_req_i.flush && (in_req_i.text_byte != CHAR_SPACE) &&
               (in_req_i.text_byte != CHAR_NL);
    fin_line = !in_req_i.flush && (in_req_i.text_byte == CHAR_NL);
    fin_go   = accept && (fin_line || (!is_data && len_q != '0));
    // a lone punctuation token not ended by a newline drops negation before it is printed
    neg_eff  = neg_q && !(!fin_line && len_q == LEN_W'(1) && is_mark(first_q));
    mem_we   = accept && is_data && (len_q < LEN_W'(MAX_TOKEN));
  end

  assign scan.start = fin_go;
  assign scan.step  = (state_q == S_EMIT) && slot_free;

  // Token buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[len_q[IDX_W-1:0]] <= in_req_i.text_byte;
    end
    rdata_q <= mem_q[ptr_q[IDX_W-1:0]];
  end

  nsm_word_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan),
    .byte_i (rdata_q),
    .ptr_i  (ptr_q),
    .len_i  (len_q),
    .hit_o  (hit)
  );

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      ptr_q       <= '0;
      pcnt_q      <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      line_q      <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // result register: take a new byte or drop the accepted one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (fin_go) begin
            line_q  <= fin_line;
            flush_q <= in_req_i.flush;
            neg_q   <= neg_eff;
            ptr_q   <= '0;
            pcnt_q  <= '0;
            if (neg_eff) begin
              state_q <= S_PREFIX;
            end else if (len_q != '0) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_TAIL;
            end
          end else if (accept && in_req_i.flush) begin
            neg_q <= 1'b0;
            ovf_q <= 1'b0;
            len_q <= '0;
          end else if (mem_we) begin
            if (len_q == '0) begin
              first_q <= in_req_i.text_byte;
            end
            len_q <= len_q + LEN_W'(1);
          end else if (accept && is_data) begin
            ovf_q <= 1'b1;
          end
        end
        S_PREFIX: begin
          if (slot_free) begin
            out_q.out_byte        <= prefix_char(pcnt_q);
            out_q.last_of_run     <= 1'b0;
            out_q.token_truncated <= ovf_q;
            pcnt_q                <= pcnt_q + 2'd1;
            if (pcnt_q == 2'(PREFIX_LEN - 1)) begin
              state_q <= (len_q != '0) ? S_READ : S_TAIL;
            end
          end
        end
        S_READ: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_q.out_byte        <= rdata_q;
            out_q.last_of_run     <= 1'b0;
            out_q.token_truncated <= ovf_q;
            ptr_q                 <= ptr_q + LEN_W'(1);
            state_q <= (ptr_q + LEN_W'(1) == len_q) ? S_TAIL : S_READ;
          end
        end
        S_TAIL: begin
          if (slot_free) begin
            out_q.out_byte        <= line_q ? CHAR_NL : CHAR_SPACE;
            out_q.last_of_run     <= 1'b1;
            out_q.token_truncated <= ovf_q;
            // scope update from the finished token
            if (line_q || flush_q) begin
              neg_q <= 1'b0;
            end else if (!neg_q) begin
              neg_q <= hit.word_hit;
            end else if (hit.last_mark) begin
              neg_q <= 1'b0;
            end
            len_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_TOKEN))
    else $error("token length beyond buffer size");

  a_ptr_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_EMIT) |-> (ptr_q < len_q))
    else $error("buffer read past the stored token");

  a_tail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL && slot_free) |=> (state_q == S_IDLE && len_q == '0 && !ovf_q))
    else $error("token state not cleared after the closing byte");

  a_flush_ends_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL && slot_free && flush_q) |=> !neg_q)
    else $error("negation still active after end of input");

endmodule

// File: bench/negation_scope_token_marker_checker.sv
// Watches both channels of the marker, predicts the marked byte stream from
// every accepted request and compares each accepted result with the oldest
// prediction still waiting.
module negation_scope_token_marker_checker import nsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  nsm_in_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  nsm_out_t out_rsp_i,
  output int       fail_count_o,
  output int       pending_o
);

  // Words that open a negation scope on their own
  string neg_vocab [$] = '{
    "never", "no", "nothing", "nowhere", "noone", "none", "not",
    "havent", "hasnt", "hadnt", "cant", "couldnt", "shouldnt", "wont",
    "wouldnt", "dont", "doesnt", "didnt", "isnt", "arent", "aint"
  };

  // Predicted state of the marker
  logic [7:0]  tok_buf [MAX_TOKEN];
  int unsigned tok_len  = 0;
  logic        neg_on   = 1'b0;
  logic        tok_lost = 1'b0;

  // Marked bytes still to come out of the block
  nsm_out_t    marked_q [$];
  int          fail_count = 0;

  function automatic bit closes_scope(logic [7:0] c);
    return c == CHAR_QUEST || c == CHAR_COMMA || c == CHAR_STOP ||
           c == CHAR_SEMI  || c == CHAR_COLON || c == CHAR_EXCL;
  endfunction

  // Token ends in n't (three bytes at least) or is one of the fixed words
  function automatic bit opens_scope();
    bit    hit;
    bit    same;
    string w;
    hit = 1'b0;
    if (tok_len >= 3 && tok_buf[tok_len-3] == CHAR_N_LOW &&
        tok_buf[tok_len-2] == CHAR_APOS && tok_buf[tok_len-1] == CHAR_T_LOW)
      hit = 1'b1;
    foreach (neg_vocab[k]) begin
      w = neg_vocab[k];
      if (w.len() == tok_len) begin
        same = 1'b1;
        for (int i = 0; i < w.len(); i++)
          if (tok_buf[i] != w[i]) same = 1'b0;
        if (same) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    nsm_out_t rec;
    rec.out_byte        = b;
    rec.last_of_run     = 1'b0;
    rec.token_truncated = tok_lost;
    marked_q.push_back(rec);
  endfunction

  // Emit the pending token with its prefix and its closing space or newline
  function automatic void close_token(bit at_line_end);
    string prefix;
    prefix = "NEG_";
    if (!at_line_end && tok_len == 1 && closes_scope(tok_buf[0]))
      neg_on = 1'b0;
    if (neg_on)
      for (int i = 0; i < prefix.len(); i++) emit_byte(prefix[i]);
    for (int i = 0; i < tok_len; i++) emit_byte(tok_buf[i]);
    emit_byte(at_line_end ? CHAR_NL : CHAR_SPACE);
    if (at_line_end)
      neg_on = 1'b0;
    else if (!neg_on)
      neg_on = opens_scope();
    else if (tok_len > 0 && closes_scope(tok_buf[tok_len-1]))
      neg_on = 1'b0;
    tok_len  = 0;
    tok_lost = 1'b0;
  endfunction

  function automatic void apply_request(nsm_in_t req);
    int       first;
    nsm_out_t tail;
    first = marked_q.size();
    if (req.flush) begin
      if (tok_len > 0) close_token(1'b0);
      tok_len  = 0;
      neg_on   = 1'b0;
      tok_lost = 1'b0;
    end else if (req.text_byte == CHAR_SPACE) begin
      if (tok_len > 0) close_token(1'b0);
    end else if (req.text_byte == CHAR_NL) begin
      close_token(1'b1);
    end else if (tok_len < MAX_TOKEN) begin
      tok_buf[tok_len] = req.text_byte;
      tok_len++;
    end else begin
      tok_lost = 1'b1;
    end
    // flag the final byte caused by this request
    if (marked_q.size() > first) begin
      tail = marked_q.pop_back();
      tail.last_of_run = 1'b1;
      marked_q.push_back(tail);
    end
  endfunction

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk_i) begin : watch
    nsm_out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (marked_q.size() == 0) begin
          fail_count++;
          $display("%0t: result %h with nothing expected", $time, out_rsp_i);
        end else begin
          want = marked_q.pop_front();
          if (out_rsp_i.out_byte !== want.out_byte) begin
            fail_count++;
            $display("%0t: out_byte expected %h, got %h",
                     $time, want.out_byte, out_rsp_i.out_byte);
          end
          if (out_rsp_i.last_of_run !== want.last_of_run) begin
            fail_count++;
            $display("%0t: last_of_run expected %b, got %b",
                     $time, want.last_of_run, out_rsp_i.last_of_run);
          end
          if (out_rsp_i.token_truncated !== want.token_truncated) begin
            fail_count++;
            $display("%0t: token_truncated expected %b, got %b",
                     $time, want.token_truncated, out_rsp_i.token_truncated);
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_request(in_req_i);
      pending_o    <= marked_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

// File: bench/negation_scope_token_marker_tb.sv
// Drives text requests into the marker, stalls its result side at random and
// gives the verdict from the checker's failure count and pending count.
module negation_scope_token_marker_tb import nsm_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned LIMIT_CYCLES = 200000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  nsm_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  nsm_out_t out_rsp_o;

  int          mismatches;
  int          pending;
  int unsigned run_cycles = 0;
  logic        hold_go;

  nsm_in_t     plan_q [$];

  // Stimulus vocabulary
  string plain_words [$] = '{
    "the", "movie", "was", "good", "bad", "i", "it", "really", "at", "all",
    "n", "nt", "t", "'t", "nots", "nev", "know", "nothings", "Not", "notn't"
  };
  string neg_words [$] = '{
    "never", "no", "nothing", "nowhere", "noone", "none", "not", "havent",
    "hasnt", "hadnt", "cant", "couldnt", "shouldnt", "wont", "wouldnt",
    "dont", "doesnt", "didnt", "isnt", "arent", "aint", "don't", "isn't",
    "can't", "won't", "n't"
  };
  string punct_words [$] = '{
    "?", ",", ";", "!", ".", ":", "good.", "so,", "why?", "yes!", "end;", "a:"
  };

  negation_scope_token_marker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  negation_scope_token_marker_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_i    (out_rsp_o),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles == LIMIT_CYCLES) begin
      $display("** negation_scope_token_marker: FAILED **");
      $finish;
    end
  end

  function automatic void push_char(logic [7:0] c);
    nsm_in_t req;
    req.text_byte = c;
    req.flush     = 1'b0;
    plan_q.push_back(req);
  endfunction

  function automatic void push_flush(logic [7:0] c);
    nsm_in_t req;
    req.text_byte = c;
    req.flush     = 1'b1;
    plan_q.push_back(req);
  endfunction

  // Word bytes, one of them replaced by a random printable byte now and then
  function automatic void push_word(string w, bit garble);
    int         pos;
    logic [7:0] c;
    pos = garble ? $urandom_range(w.len() - 1) : -1;
    for (int i = 0; i < w.len(); i++) begin
      c = (i == pos) ? 8'($urandom_range(33, 126)) : w[i];
      push_char(c);
    end
  endfunction

  // Mostly well-formed text; noise, long tokens, space runs and flushes mixed in
  function automatic void plan_random(int unsigned n_items);
    int unsigned first;
    int unsigned kind;
    int unsigned sep;
    string       w;
    first = plan_q.size();
    while (plan_q.size() - first < n_items) begin
      kind = $urandom_range(99);
      w    = "";
      if (kind < 40)
        w = plain_words[$urandom_range(plain_words.size() - 1)];
      else if (kind < 60)
        w = neg_words[$urandom_range(neg_words.size() - 1)];
      else if (kind < 72)
        w = punct_words[$urandom_range(punct_words.size() - 1)];
      else if (kind < 76) begin
        // around the buffer limit
        repeat ($urandom_range(MAX_TOKEN - 2, MAX_TOKEN + 4))
          push_char(8'($urandom_range(97, 122)));
        push_char(CHAR_SPACE);
      end else if (kind < 86) begin
        repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(255)));
      end else if (kind < 92) begin
        repeat ($urandom_range(2, 4)) push_char(CHAR_SPACE);
      end else if (kind < 96)
        push_flush(8'($urandom_range(255)));
      else
        push_char(CHAR_NL);
      if (w.len() > 0) begin
        push_word(w, $urandom_range(99) < 10);
        sep = $urandom_range(99);
        if (sep < 78)      push_char(CHAR_SPACE);
        else if (sep < 94) push_char(CHAR_NL);
        else               push_flush(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic send_item(nsm_in_t req, bit may_idle);
    if (may_idle && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Result side: random stalls, one long hold-off, one stretch without stalls
  initial begin : receiver
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          hold_taken;
    rx_cycle    = 0;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_cycle >= 1000 && rx_cycle < 2000)
        out_stall_i <= 1'b0;
      else
        out_stall_i <= ($urandom_range(99) < 10);
    end
  end

  // Request side and verdict
  initial begin : sender
    int unsigned directed;
    int unsigned hold_at;
    int unsigned pause_at;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    hold_go    = 1'b0;

    // negation word, space run, extreme bytes under the prefix
    push_word("no ", 1'b0);
    push_char(CHAR_SPACE);
    push_char(8'hFF);
    push_char(8'h00);
    push_char(CHAR_SPACE);
    // lone comma clears the scope before it is printed
    push_word(", ", 1'b0);
    // newline on an empty token while negated
    push_word("no ", 1'b0);
    push_char(CHAR_NL);
    // short token, then the bare n't
    push_word("t ", 1'b0);
    push_word("n't ", 1'b0);
    // flush with a pending token, then on an empty one
    push_char("x");
    push_flush(8'hFF);
    push_flush(8'h00);
    directed = plan_q.size();
    plan_random(RANDOM_ITEMS);
    hold_at  = directed + 80;
    pause_at = directed + 280;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned idx = 0; idx < plan_q.size(); idx++) begin
      if (idx == pause_at) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      if (idx == hold_at) hold_go <= 1'b1;
      send_item(plan_q[idx], !(idx >= directed + 150 && idx < directed + 240));
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("** negation_scope_token_marker: PASSED **");
    else
      $display("** negation_scope_token_marker: FAILED **");
    $finish;
  end

endmodule
